/* sv/assert_macros.svh */
// Assertion macros for the checker file of the sequencer.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define ASSERT_SYNC_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/i2cms_pkg.sv */
// Package of the I2C master transfer sequencer: request, status, action and
// result codes, the decoded command kind and the command word type.
// No dependencies.
package i2cms_pkg;

  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_START_WR = 2'd1;
  localparam logic [1:0] REQ_START_RD = 2'd2;
  localparam logic [1:0] REQ_STATUS   = 2'd3;

  localparam logic [7:0] STATUS_MASK      = 8'hF8;
  localparam logic [7:0] ST_BUS_ERROR     = 8'h00;
  localparam logic [7:0] ST_START         = 8'h08;
  localparam logic [7:0] ST_REP_START     = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK    = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK   = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST      = 8'h38;
  localparam logic [7:0] ST_MR_SLA_ACK    = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK   = 8'h48;
  localparam logic [7:0] ST_MR_DATA_ACK   = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK  = 8'h58;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_LOAD    = 3'd2;
  localparam logic [2:0] ACT_ACK     = 3'd3;
  localparam logic [2:0] ACT_NACK    = 3'd4;
  localparam logic [2:0] ACT_STOP    = 3'd5;
  localparam logic [2:0] ACT_RELEASE = 3'd6;

  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_NACK  = 2'd1;
  localparam logic [1:0] RES_ERROR = 2'd2;
  localparam logic [1:0] RES_BUSY  = 2'd3;

  typedef enum logic [3:0] {
    K_LOAD,
    K_START_WR,
    K_START_RD,
    K_ADDR,
    K_TX_ACK,
    K_SLA_NACK,
    K_DATA_NACK,
    K_ARB,
    K_RX_DATA,
    K_RX_ADDR_ACK,
    K_RX_LAST,
    K_BUS_ERR,
    K_NONE
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] dev_addr;
    logic [7:0] len;
    logic [7:0] data;
    logic       len_over;
  } cmd_t;

endpackage

/* sv/i2cms_req_if.sv */
// Request channel of the sequencer: valid/ready handshake and input fields.
// Depends on nothing but the language.
interface i2cms_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] dev_addr;
  logic [7:0] transfer_length;
  logic [7:0] tx_byte;
  logic [7:0] bus_status;
  logic [7:0] rx_byte;

  modport source (output valid, req_type, dev_addr, transfer_length, tx_byte,
                  bus_status, rx_byte, input ready);
  modport sink (input valid, req_type, dev_addr, transfer_length, tx_byte,
                bus_status, rx_byte, output ready);
endinterface

/* sv/i2cms_res_if.sv */
// Result channel of the sequencer: valid/ready handshake and output fields.
// Depends on nothing but the language.
interface i2cms_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_action;
  logic [7:0] out_byte;
  logic       rx_valid;
  logic [7:0] rx_data;
  logic [4:0] rx_position;
  logic       done_res;
  logic [1:0] result_code;
  logic [5:0] byte_count;

  modport source (output valid, bus_action, out_byte, rx_valid, rx_data,
                  rx_position, done_res, result_code, byte_count, input ready);
  modport sink (input valid, bus_action, out_byte, rx_valid, rx_data,
                rx_position, done_res, result_code, byte_count, output ready);
endinterface

/* sv/i2cms_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* sv/i2cms_front.sv */
// Front end of the sequencer: takes request words and decodes them into
// command words for the queue. Uses i2cms_pkg and i2cms_req_if.
module i2cms_front #(
  parameter int BUFFER_DEPTH = 32
) (
  i2cms_req_if.sink         req,
  output logic              push,
  output i2cms_pkg::cmd_t   cmd,
  input  logic              q_ready
);
  import i2cms_pkg::*;

  logic [7:0] status;

  assign push      = req.valid;
  assign req.ready = q_ready;
  assign status    = req.bus_status & STATUS_MASK;

  always_comb begin
    cmd.kind     = K_NONE;
    cmd.dev_addr = req.dev_addr;
    cmd.len      = req.transfer_length;
    cmd.data     = req.rx_byte;
    cmd.len_over = req.transfer_length > 8'(BUFFER_DEPTH);
    case (req.req_type)
      REQ_LOAD: begin
        cmd.kind = K_LOAD;
        cmd.data = req.tx_byte;
      end
      REQ_START_WR: cmd.kind = K_START_WR;
      REQ_START_RD: cmd.kind = K_START_RD;
      default: begin
        case (status)
          ST_START, ST_REP_START:          cmd.kind = K_ADDR;
          ST_MT_SLA_ACK, ST_MT_DATA_ACK:   cmd.kind = K_TX_ACK;
          ST_MT_SLA_NACK, ST_MR_SLA_NACK:  cmd.kind = K_SLA_NACK;
          ST_MT_DATA_NACK:                 cmd.kind = K_DATA_NACK;
          ST_ARB_LOST:                     cmd.kind = K_ARB;
          ST_MR_SLA_ACK:                   cmd.kind = K_RX_ADDR_ACK;
          ST_MR_DATA_ACK:                  cmd.kind = K_RX_DATA;
          ST_MR_DATA_NACK:                 cmd.kind = K_RX_LAST;
          ST_BUS_ERROR:                    cmd.kind = K_BUS_ERR;
          default:                         cmd.kind = K_NONE;
        endcase
      end
    endcase
  end
endmodule

/* sv/i2cms_queue.sv */
// Two-entry queue of command words between the front end and the back end.
// Uses i2cms_pkg.
module i2cms_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i2cms_pkg::cmd_t din,
  output logic            ready,
  output logic            valid,
  output i2cms_pkg::cmd_t dout,
  input  logic            pop
);
  import i2cms_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       slot [DEPTH];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push_ok;

  assign ready   = count != 2'(DEPTH);
  assign valid   = count != 2'd0;
  assign dout    = slot[rd_ptr];
  assign push_ok = push && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count + 2'(push_ok) - 2'(pop);
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot[wr_ptr] <= din;
    end
  end
endmodule

/* sv/i2cms_back.sv */
// Back end of the sequencer: transfer state, byte buffer and result register.
// Uses i2cms_pkg, i2cms_res_if and i2cms_ram.
module i2cms_back #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  i2cms_pkg::cmd_t cmd,
  output logic            pop,
  i2cms_res_if.source     res
);
  import i2cms_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);

  typedef enum logic [1:0] {MODE_READY, MODE_RX, MODE_TX} mode_t;
  typedef enum logic [2:0] {ERR_NONE, ERR_SLA_NACK, ERR_DATA_NACK, ERR_ARB, ERR_BUS} err_t;

  mode_t         mode, mode_next;
  err_t          error_mark, error_mark_next;
  logic [7:0]    address_rw, address_rw_next;
  logic [PW-1:0] position, position_next;
  logic [PW-1:0] end_count, end_count_next;
  logic [PW-1:0] load_pointer, load_pointer_next;

  logic [2:0]    act;
  logic [7:0]    obyte;
  logic          rxv;
  logic [7:0]    rxd;
  logic [4:0]    rxp;
  logic          done;
  logic [1:0]    code;
  logic [5:0]    count;
  logic          fin;
  logic [2:0]    fin_act;
  logic [PW:0]   count_full;
  logic [PW:0]   end_p1;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          byp_hit;
  logic [7:0]    byp_data;
  logic [7:0]    buf_byte;

  assign pop      = q_valid && (!res.valid || res.ready);
  assign rd_addr  = position_next[AW-1:0];
  assign buf_byte = byp_hit ? byp_data : rd_data;

  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    mode_next         = mode;
    error_mark_next   = error_mark;
    address_rw_next   = address_rw;
    position_next     = position;
    end_count_next    = end_count;
    load_pointer_next = load_pointer;
    act     = ACT_NONE;
    obyte   = 8'h00;
    rxv     = 1'b0;
    rxd     = 8'h00;
    rxp     = 5'd0;
    done    = 1'b0;
    code    = RES_OK;
    count   = 6'd0;
    fin     = 1'b0;
    fin_act = ACT_NONE;
    wr_en   = 1'b0;
    wr_addr = load_pointer[AW-1:0];
    wr_data = cmd.data;
    end_p1     = {1'b0, end_count} + 1'b1;
    count_full = '0;
    if (pop) begin
      case (cmd.kind)
        K_LOAD, K_START_WR, K_START_RD: begin
          if (mode != MODE_READY) begin
            done = 1'b1;
            code = RES_BUSY;
          end else if (cmd.kind == K_LOAD) begin
            if (load_pointer < DEPTH_P) begin
              wr_en             = 1'b1;
              load_pointer_next = load_pointer + 1'b1;
            end
          end else if (cmd.len_over) begin
            done = 1'b1;
            code = RES_ERROR;
          end else begin
            load_pointer_next = '0;
            if (cmd.kind == K_START_RD && cmd.len == 8'd0) begin
              done = 1'b1;
              code = RES_OK;
            end else begin
              error_mark_next = ERR_NONE;
              position_next   = '0;
              act             = ACT_START;
              if (cmd.kind == K_START_WR) begin
                mode_next       = MODE_TX;
                end_count_next  = PW'(cmd.len);
                address_rw_next = {cmd.dev_addr, 1'b0};
              end else begin
                mode_next       = MODE_RX;
                end_count_next  = PW'(cmd.len - 8'd1);
                address_rw_next = {cmd.dev_addr, 1'b1};
              end
            end
          end
        end
        default: begin
          if (mode != MODE_READY) begin
            case (cmd.kind)
              K_ADDR: begin
                act   = ACT_LOAD;
                obyte = address_rw;
              end
              K_TX_ACK: begin
                if (position < end_count && position < DEPTH_P) begin
                  act           = ACT_LOAD;
                  obyte         = buf_byte;
                  position_next = position + 1'b1;
                end else begin
                  fin     = 1'b1;
                  fin_act = ACT_STOP;
                end
              end
              K_SLA_NACK: begin
                error_mark_next = ERR_SLA_NACK;
                fin             = 1'b1;
                fin_act         = ACT_STOP;
              end
              K_DATA_NACK: begin
                error_mark_next = ERR_DATA_NACK;
                fin             = 1'b1;
                fin_act         = ACT_STOP;
              end
              K_ARB: begin
                error_mark_next = ERR_ARB;
                fin             = 1'b1;
                fin_act         = ACT_RELEASE;
              end
              K_BUS_ERR: begin
                error_mark_next = ERR_BUS;
                fin             = 1'b1;
                fin_act         = ACT_STOP;
              end
              K_RX_ADDR_ACK: begin
                act = (position < end_count) ? ACT_ACK : ACT_NACK;
              end
              K_RX_DATA, K_RX_LAST: begin
                rxv = 1'b1;
                rxd = cmd.data;
                rxp = 5'(position);
                if (position < DEPTH_P) begin
                  wr_en         = 1'b1;
                  wr_addr       = position[AW-1:0];
                  position_next = position + 1'b1;
                end
                if (cmd.kind == K_RX_LAST) begin
                  fin     = 1'b1;
                  fin_act = ACT_STOP;
                end else begin
                  act = (position_next < end_count) ? ACT_ACK : ACT_NACK;
                end
              end
              default: ;
            endcase
          end
        end
      endcase
      if (fin) begin
        count_full = {1'b0, position_next};
        if (mode == MODE_RX && count_full > end_p1) begin
          count_full = end_p1;
        end
        act       = fin_act;
        done      = 1'b1;
        count     = 6'(count_full);
        mode_next = MODE_READY;
        case (error_mark_next)
          ERR_NONE:                    code = RES_OK;
          ERR_SLA_NACK, ERR_DATA_NACK: code = RES_NACK;
          default:                     code = RES_ERROR;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_READY;
      error_mark   <= ERR_NONE;
      address_rw   <= 8'h00;
      position     <= '0;
      end_count    <= '0;
      load_pointer <= '0;
      byp_hit      <= 1'b0;
      res.valid    <= 1'b0;
    end else begin
      mode         <= mode_next;
      error_mark   <= error_mark_next;
      address_rw   <= address_rw_next;
      position     <= position_next;
      end_count    <= end_count_next;
      load_pointer <= load_pointer_next;
      byp_hit      <= wr_en && (wr_addr == rd_addr);
      byp_data     <= wr_data;
      if (pop) begin
        res.valid       <= 1'b1;
        res.bus_action  <= act;
        res.out_byte    <= obyte;
        res.rx_valid    <= rxv;
        res.rx_data     <= rxd;
        res.rx_position <= rxp;
        res.done_res    <= done;
        res.result_code <= code;
        res.byte_count  <= count;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end
endmodule

/* sv/i2c_master_transfer_sequencer_top.sv */
// Top level of the I2C master transfer sequencer.
// Uses i2cms_pkg, the channel interfaces, i2cms_front, i2cms_queue, i2cms_back.

// The sequencer takes one word per clock cycle while its command queue has room
// and returns exactly one result word for each; with the result side always ready
// it sustains one word per cycle. A request is written into the two-entry command
// queue when it is taken, and the back end then updates the transfer state and
// registers the result. Write data and received bytes share a buffer RAM of
// BUFFER_DEPTH bytes with registered read; it is not cleared after reset, so a
// write transfer must only send bytes loaded first.
module i2c_master_transfer_sequencer_top #(
  parameter int BUFFER_DEPTH = 32
) (
  input logic         clk,
  input logic         rst,
  i2cms_req_if.sink   req,
  i2cms_res_if.source res
);
  import i2cms_pkg::*;

  logic push;
  logic q_ready;
  logic q_valid;
  logic pop;
  cmd_t push_cmd;
  cmd_t q_cmd;

  i2cms_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_front (
    .req     (req),
    .push    (push),
    .cmd     (push_cmd),
    .q_ready (q_ready)
  );

  i2cms_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_cmd),
    .ready (q_ready),
    .valid (q_valid),
    .dout  (q_cmd),
    .pop   (pop)
  );

  i2cms_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .cmd     (q_cmd),
    .pop     (pop),
    .res     (res)
  );
endmodule

/* sv/i2cms_checker.sv */
// Port-level checker for the sequencer result channel, bound to the top level.
// Uses i2cms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cms_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] bus_action,
  input logic [7:0] out_byte,
  input logic       done_res,
  input logic [1:0] result_code,
  input logic [5:0] byte_count
);
  import i2cms_pkg::*;

  `ASSERT_SYNC_NR(a_reset_empty, clk, rst |=> !res_valid, "result valid after reset")
  `ASSERT_SYNC(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(bus_action) && $stable(out_byte) && $stable(byte_count), "stalled result word changed")
  `ASSERT_SYNC(a_out_byte, clk, rst, res_valid && bus_action != ACT_LOAD |-> out_byte == 8'h00, "byte given without a load action")
  `ASSERT_SYNC(a_done_fields, clk, rst, res_valid && !done_res |-> result_code == RES_OK && byte_count == 6'd0, "completion fields set without done")
  `ASSERT_SYNC(a_busy_quiet, clk, rst, res_valid && done_res && result_code == RES_BUSY |-> bus_action == ACT_NONE && byte_count == 6'd0, "rejected request caused bus activity")
endmodule

bind i2c_master_transfer_sequencer_top i2cms_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .bus_action  (res.bus_action),
  .out_byte    (res.out_byte),
  .done_res    (res.done_res),
  .result_code (res.result_code),
  .byte_count  (res.byte_count)
);

/* dv/tb_i2c_master_transfer_sequencer_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the I2C master transfer sequencer: drives request words,
// predicts every result word in a behavioral model of the sequencer and checks them.
// Depends on i2cms_pkg, i2cms_req_if, i2cms_res_if and i2c_master_transfer_sequencer_top.
module tb_i2c_master_transfer_sequencer_top;
  import i2cms_pkg::*;

  localparam int DEPTH = 32;
  localparam int SHOWN_LIMIT = 10;
  localparam int QUIET_LIMIT = 1000;
  localparam logic [7:0] ST_UNUSED = 8'hF8;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_RECEIVE, SEQ_TRANSMIT} seq_mode_t;
  typedef enum logic [2:0] {
    FAIL_NONE, FAIL_ADDR_NACK, FAIL_DATA_NACK, FAIL_ARB, FAIL_BUS
  } fail_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic [7:0] transfer_length;
    logic [7:0] tx_byte;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
  } req_word_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] out_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [4:0] rx_position;
    logic       done_res;
    logic [1:0] result_code;
    logic [5:0] byte_count;
  } res_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  i2cms_req_if req_ch();
  i2cms_res_if res_ch();

  i2c_master_transfer_sequencer_top #(.BUFFER_DEPTH(DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  seq_mode_t   seq_mode;
  fail_t       fail_mark;
  logic [7:0]  addr_rw;
  logic [7:0]  xfer_buf [DEPTH];
  bit          buf_written [DEPTH];
  int unsigned buf_pos;
  int unsigned end_cnt;
  int unsigned load_ptr;
  logic [2:0]  last_action;

  res_word_t   expected_results [$];
  res_word_t   got_word;
  res_word_t   want_word;
  int          mismatch_count = 0;
  int          result_index = 0;
  int          accepted_items = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;

  function automatic void close_transfer(inout res_word_t r, input logic [2:0] act);
    int unsigned n;
    n = buf_pos;
    if (seq_mode == SEQ_RECEIVE && n > end_cnt + 1) n = end_cnt + 1;
    r.bus_action = act;
    r.done_res = 1'b1;
    case (fail_mark)
      FAIL_NONE: r.result_code = RES_OK;
      FAIL_ADDR_NACK, FAIL_DATA_NACK: r.result_code = RES_NACK;
      default: r.result_code = RES_ERROR;
    endcase
    r.byte_count = 6'(n);
    seq_mode = SEQ_IDLE;
  endfunction

  function automatic void take_rx_byte(inout res_word_t r, input logic [7:0] b);
    r.rx_valid = 1'b1;
    r.rx_data = b;
    r.rx_position = 5'(buf_pos);
    if (buf_pos < DEPTH) begin
      xfer_buf[buf_pos] = b;
      buf_written[buf_pos] = 1'b1;
      buf_pos++;
    end
  endfunction

  function automatic res_word_t sequence_step(input req_word_t w);
    res_word_t r;
    logic [7:0] st;
    r = '0;
    st = w.bus_status & STATUS_MASK;
    if (w.req_type != REQ_STATUS) begin
      if (seq_mode != SEQ_IDLE) begin
        r.done_res = 1'b1;
        r.result_code = RES_BUSY;
        return r;
      end
      if (w.req_type == REQ_LOAD) begin
        if (load_ptr < DEPTH) begin
          xfer_buf[load_ptr] = w.tx_byte;
          buf_written[load_ptr] = 1'b1;
          load_ptr++;
        end
        return r;
      end
      if (w.transfer_length > DEPTH) begin
        r.done_res = 1'b1;
        r.result_code = RES_ERROR;
        return r;
      end
      load_ptr = 0;
      if (w.req_type == REQ_START_RD && w.transfer_length == 0) begin
        r.done_res = 1'b1;
        r.result_code = RES_OK;
        return r;
      end
      fail_mark = FAIL_NONE;
      buf_pos = 0;
      if (w.req_type == REQ_START_WR) begin
        seq_mode = SEQ_TRANSMIT;
        end_cnt = w.transfer_length;
        addr_rw = {w.dev_addr, 1'b0};
      end else begin
        seq_mode = SEQ_RECEIVE;
        end_cnt = w.transfer_length - 1;
        addr_rw = {w.dev_addr, 1'b1};
      end
      r.bus_action = ACT_START;
      return r;
    end
    if (seq_mode == SEQ_IDLE) return r;
    case (st)
      ST_START, ST_REP_START: begin
        r.bus_action = ACT_LOAD;
        r.out_byte = addr_rw;
      end
      ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
        if (buf_pos < end_cnt && buf_pos < DEPTH) begin
          r.bus_action = ACT_LOAD;
          r.out_byte = xfer_buf[buf_pos];
          buf_pos++;
        end else begin
          close_transfer(r, ACT_STOP);
        end
      end
      ST_MT_SLA_NACK, ST_MR_SLA_NACK: begin
        fail_mark = FAIL_ADDR_NACK;
        close_transfer(r, ACT_STOP);
      end
      ST_MT_DATA_NACK: begin
        fail_mark = FAIL_DATA_NACK;
        close_transfer(r, ACT_STOP);
      end
      ST_ARB_LOST: begin
        fail_mark = FAIL_ARB;
        close_transfer(r, ACT_RELEASE);
      end
      ST_MR_SLA_ACK, ST_MR_DATA_ACK: begin
        if (st == ST_MR_DATA_ACK) take_rx_byte(r, w.rx_byte);
        r.bus_action = (buf_pos < end_cnt) ? ACT_ACK : ACT_NACK;
      end
      ST_MR_DATA_NACK: begin
        take_rx_byte(r, w.rx_byte);
        close_transfer(r, ACT_STOP);
      end
      ST_BUS_ERROR: begin
        fail_mark = FAIL_BUS;
        close_transfer(r, ACT_STOP);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic string show_result(input res_word_t r);
    return $sformatf("action=%0d byte=%02h rx=%0d data=%02h pos=%0d done=%0d code=%0d count=%0d",
                     r.bus_action, r.out_byte, r.rx_valid, r.rx_data, r.rx_position,
                     r.done_res, r.result_code, r.byte_count);
  endfunction

  function automatic req_word_t random_word();
    req_word_t w;
    w.req_type = 2'($urandom_range(3));
    w.dev_addr = 7'($urandom_range(127));
    w.transfer_length = 8'($urandom_range(255));
    w.tx_byte = 8'($urandom_range(255));
    w.bus_status = 8'($urandom_range(255));
    w.rx_byte = 8'($urandom_range(255));
    return w;
  endfunction

  function automatic req_word_t load_word(input logic [7:0] b);
    req_word_t w;
    w = random_word();
    w.req_type = REQ_LOAD;
    w.tx_byte = b;
    return w;
  endfunction

  function automatic req_word_t start_word(input logic [1:0] kind, input logic [6:0] addr,
                                           input logic [7:0] len);
    req_word_t w;
    w = random_word();
    w.req_type = kind;
    w.dev_addr = addr;
    w.transfer_length = len;
    return w;
  endfunction

  function automatic req_word_t status_word(input logic [7:0] code, input logic [7:0] b);
    req_word_t w;
    w = random_word();
    w.req_type = REQ_STATUS;
    w.bus_status = code | 8'($urandom_range(7));
    w.rx_byte = b;
    return w;
  endfunction

  // An address-ack or data-ack status must never make the block send a buffer entry that
  // was never written, so such an event is turned into a data nack.
  task automatic send_word(input req_word_t w);
    logic [7:0] st;
    st = w.bus_status & STATUS_MASK;
    if (w.req_type == REQ_STATUS && (st == ST_MT_SLA_ACK || st == ST_MT_DATA_ACK) &&
        seq_mode != SEQ_IDLE && buf_pos < end_cnt && buf_pos < DEPTH &&
        !buf_written[buf_pos]) begin
      w.bus_status = ST_MT_DATA_NACK | (w.bus_status & ~STATUS_MASK);
    end
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= w.req_type;
    req_ch.dev_addr <= w.dev_addr;
    req_ch.transfer_length <= w.transfer_length;
    req_ch.tx_byte <= w.tx_byte;
    req_ch.bus_status <= w.bus_status;
    req_ch.rx_byte <= w.rx_byte;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (!(w.req_type == REQ_STATUS && seq_mode == SEQ_IDLE)) accepted_items++;
    want_word = sequence_step(w);
    last_action = want_word.bus_action;
    expected_results.push_back(want_word);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Feeds status events until the transfer in progress ends, mostly in the order a
  // real bus produces them, with some random codes and requests mixed in.
  task automatic finish_transfer();
    int stage;
    int steps;
    int r;
    logic clean;
    logic [7:0] code;
    stage = 0;
    steps = 0;
    while (seq_mode != SEQ_IDLE) begin
      clean = 1'b0;
      code = ST_BUS_ERROR;
      if (steps >= 80) begin
        code = ST_BUS_ERROR;
      end else if ($urandom_range(15) == 0) begin
        code = 8'($urandom_range(31) * 8);
      end else if (seq_mode == SEQ_TRANSMIT) begin
        clean = 1'b1;
        case (stage)
          0: code = $urandom_range(1) ? ST_START : ST_REP_START;
          1: code = ($urandom_range(11) == 0) ? ST_MT_SLA_NACK : ST_MT_SLA_ACK;
          default: begin
            r = $urandom_range(19);
            code = (r == 0) ? ST_MT_DATA_NACK : (r == 1) ? ST_ARB_LOST :
                   (r == 2) ? ST_BUS_ERROR : ST_MT_DATA_ACK;
          end
        endcase
      end else begin
        clean = 1'b1;
        case (stage)
          0: code = $urandom_range(1) ? ST_START : ST_REP_START;
          1: code = ($urandom_range(9) == 0) ? ST_MR_SLA_NACK : ST_MR_SLA_ACK;
          default: begin
            if (last_action == ACT_ACK)
              code = ($urandom_range(11) == 0) ? ST_MR_DATA_NACK : ST_MR_DATA_ACK;
            else
              code = ($urandom_range(5) == 0) ? ST_MR_DATA_ACK : ST_MR_DATA_NACK;
          end
        endcase
      end
      if (steps < 80 && !clean && $urandom_range(3) == 0) begin
        send_word(start_word(2'($urandom_range(2)), 7'($urandom_range(127)),
                             8'($urandom_range(255))));
      end else begin
        send_word(status_word(code, 8'($urandom_range(255))));
      end
      steps++;
      if (clean && stage < 2) stage++;
    end
  endtask

  task automatic test_directed_cases();
    send_word(status_word(ST_START, 8'h00));
    send_word(load_word(8'h00));
    send_word(load_word(8'hFF));
    send_word(start_word(REQ_START_WR, 7'h7F, 8'd2));
    send_word(load_word(8'hA5));
    send_word(status_word(ST_START, 8'h00));
    send_word(status_word(ST_MT_SLA_ACK, 8'hFF));
    send_word(status_word(ST_MT_DATA_ACK, 8'h00));
    send_word(status_word(ST_MT_DATA_ACK, 8'hFF));
    send_word(start_word(REQ_START_RD, 7'h00, 8'd0));
    send_word(start_word(REQ_START_WR, 7'h12, 8'd255));
    send_word(start_word(REQ_START_RD, 7'h55, 8'd2));
    send_word(status_word(ST_REP_START, 8'h00));
    send_word(status_word(ST_UNUSED, 8'h00));
    send_word(status_word(ST_MR_SLA_ACK, 8'h00));
    send_word(status_word(ST_MR_DATA_ACK, 8'hFF));
    send_word(status_word(ST_MR_DATA_NACK, 8'h00));
    send_word(start_word(REQ_START_RD, 7'h2A, 8'd32));
    send_word(status_word(ST_MR_SLA_NACK, 8'h00));
    send_word(start_word(REQ_START_WR, 7'h01, 8'd1));
    send_word(status_word(ST_MT_SLA_ACK, 8'h00));
    send_word(status_word(ST_MT_DATA_NACK, 8'h00));
    send_word(start_word(REQ_START_WR, 7'h40, 8'd0));
    send_word(status_word(ST_ARB_LOST, 8'h00));
    send_word(start_word(REQ_START_RD, 7'h3C, 8'd3));
    send_word(status_word(ST_BUS_ERROR, 8'h00));
  endtask

  task automatic test_random_traffic(input int count);
    int first;
    int pick;
    int n;
    int lead;
    int len;
    first = accepted_items;
    while (accepted_items - first < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        n = ($urandom_range(15) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
        repeat (n) send_word(load_word(8'($urandom_range(255))));
        lead = 0;
        while (lead < DEPTH && buf_written[lead]) lead++;
        if ($urandom_range(7) == 0) len = $urandom_range(0, lead);
        else len = $urandom_range(0, (lead < 8) ? lead : 8);
        send_word(start_word(REQ_START_WR, 7'($urandom_range(127)), 8'(len)));
        finish_transfer();
      end else if (pick < 85) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(0, DEPTH) : $urandom_range(1, 6);
        send_word(start_word(REQ_START_RD, 7'($urandom_range(127)), 8'(len)));
        finish_transfer();
      end else if (pick < 93) begin
        repeat ($urandom_range(2, 6)) send_word(random_word());
        finish_transfer();
      end else if ($urandom_range(1) == 0) begin
        send_word(start_word(2'($urandom_range(1, 2)), 7'($urandom_range(127)),
                             8'($urandom_range(DEPTH + 1, 255))));
      end else begin
        send_word(start_word(REQ_START_RD, 7'($urandom_range(127)), 8'd0));
      end
      if ($urandom_range(39) == 0) wait_drained();
    end
  endtask

  // The result side holds off while a long read goes on, so the block fills up and
  // stops taking requests until the hold ends.
  task automatic test_input_stall();
    wait_drained();
    @(posedge clk);
    hold_left = 80;
    send_word(start_word(REQ_START_RD, 7'($urandom_range(127)), 8'(DEPTH)));
    finish_transfer();
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got_word.bus_action = res_ch.bus_action;
      got_word.out_byte = res_ch.out_byte;
      got_word.rx_valid = res_ch.rx_valid;
      got_word.rx_data = res_ch.rx_data;
      got_word.rx_position = res_ch.rx_position;
      got_word.done_res = res_ch.done_res;
      got_word.result_code = res_ch.result_code;
      got_word.byte_count = res_ch.byte_count;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_LIMIT)
          $display("result %0d arrived with none expected: %s", result_index,
                   show_result(got_word));
      end else begin
        want_word = expected_results.pop_front();
        if (got_word !== want_word) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_LIMIT)
            $display("result %0d differs\n  expected %s\n  actual   %s", result_index,
                     show_result(want_word), show_result(got_word));
        end
      end
      result_index++;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("i2c_master_transfer_sequencer_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_LOAD;
    req_ch.dev_addr = '0;
    req_ch.transfer_length = '0;
    req_ch.tx_byte = '0;
    req_ch.bus_status = '0;
    req_ch.rx_byte = '0;
    seq_mode = SEQ_IDLE;
    fail_mark = FAIL_NONE;
    addr_rw = '0;
    buf_pos = 0;
    end_cnt = 0;
    load_ptr = 0;
    last_action = ACT_NONE;
    foreach (buf_written[i]) buf_written[i] = 1'b0;
    foreach (xfer_buf[i]) xfer_buf[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    wait_drained();
    test_random_traffic(370);
    test_input_stall();

    send_idle_pct = 49;
    recv_stall_pct = 0;
    test_random_traffic(370);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 49;
    test_random_traffic(370);
    wait_drained();

    send_idle_pct = 38;
    recv_stall_pct = 38;
    test_random_traffic(370);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("i2c_master_transfer_sequencer_top: match");
    end else begin
      $display("i2c_master_transfer_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule
